// ----- hdl/gf_gauss_jordan_inverter_unit_defines.svh -----
// Assertion macros for the inverter unit.
`ifndef GF_GAUSS_JORDAN_INVERTER_UNIT_DEFINES_SVH
`define GF_GAUSS_JORDAN_INVERTER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define GJI_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GJI_ASSERT_NR(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GJI_ASSERT(label, clk, rst_n, prop, msg)
`define GJI_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ----- hdl/gji_pkg.sv -----
// ----------------------------------------------------------------------------
// gji_pkg
// Shared constants for the Gauss-Jordan inverter.
// ----------------------------------------------------------------------------
package gji_pkg;
	localparam int ELEM_W = 8;
	localparam int SIZE_W = 4;
	localparam int POLY_W = 9;
	localparam int CFG_W  = 9;
	localparam logic [0:0] REG_MATRIX_SIZE = 1'd0;
	localparam logic [0:0] REG_FIELD_POLY  = 1'd1;
endpackage

// ----- hdl/gji_stream_if.sv -----
// ----------------------------------------------------------------------------
// gji_stream_if
// Valid/ready channel carrying a generic payload.
// ----------------------------------------------------------------------------
interface gji_stream_if #(parameter int W = 8);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/gji_gf_mul.sv -----
// ----------------------------------------------------------------------------
// gji_gf_mul
// Registered GF(2^m) multiply, low bits of the polynomial as the reduction.
// ----------------------------------------------------------------------------
module gji_gf_mul #(
	parameter int SB = 8
) (
	input  logic          clk,
	input  logic [SB-1:0] a,
	input  logic [SB-1:0] b,
	input  logic [SB-1:0] poly,
	output logic [SB-1:0] p_s1
);
	logic [SB-1:0] p;
	always_comb begin
		logic [SB-1:0] x;
		logic          hi;
		x = a;
		p = '0;
		for (int i = 0; i < SB; i++) begin
			if (b[i]) p = p ^ x;
			hi = x[SB-1];
			x = {x[SB-2:0], 1'b0};
			if (hi) x = x ^ poly;
		end
	end
	always_ff @(posedge clk) begin
		p_s1 <= p;
	end
endmodule

// ----- hdl/gf_gauss_jordan_inverter_unit.sv -----
// After the last element the unit works column by column (pivot search, a row swap when
// needed, pivot inversion, normalisation, elimination); the inverse then streams out, each
// element read from the RAM only after the previous one has reached the output register.
// Throughput: one matrix at a time; elements are taken one per cycle while loading and
// refused during elimination and output. The single RAM, with one read and one write port, sets the pace.
// Reset clears control state and restores the default size and polynomial; the store is undefined until loaded.
// ----------------------------------------------------------------------------
// gf_gauss_jordan_inverter_unit
// Gauss-Jordan matrix inversion over GF(2^m) around one augmented-matrix RAM.
// ----------------------------------------------------------------------------
`include "gf_gauss_jordan_inverter_unit_defines.svh"
module gf_gauss_jordan_inverter_unit #(
	parameter int MAX_DIM = 8,
	parameter int SYMBOL_BITS = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [0:0] cfg_index,
	input  logic [gji_pkg::CFG_W-1:0] cfg_data,
	gji_stream_if.sink   in_ch,
	gji_stream_if.source out_ch
);
	import gji_pkg::*;
	localparam int SB = SYMBOL_BITS;
	localparam int DW = $clog2(MAX_DIM + 1);
	localparam int IW = $clog2(MAX_DIM);
	localparam int CW = IW + 1;
	localparam int AW = IW + CW;
	localparam int DEPTH = 1 << AW;
	localparam int ICW = $clog2(SB);

	localparam logic [3:0] ST_LOAD = 4'd0, ST_INIT = 4'd1, ST_PIV_RD = 4'd2,
		ST_PIV_CMP = 4'd3, ST_SWAP = 4'd4, ST_INV = 4'd5, ST_NORM = 4'd6,
		ST_ELIM_R = 4'd7, ST_ELIM = 4'd8, ST_OUT = 4'd9;

	logic [SIZE_W-1:0] size_q;
	logic [POLY_W-1:0] poly_q;
	logic [3:0] state_q;
	logic [6:0] load_q;
	logic       sing_q;
	logic [SB-1:0] mem [DEPTH];
	logic [SB-1:0] rd_s1;
	logic [AW-1:0] raddr, waddr;
	logic          we;
	logic [SB-1:0] wdata;

	logic [DW-1:0] n;
	always_comb begin
		if (size_q == '0) n = DW'(1);
		else if (32'(size_q) > MAX_DIM) n = DW'(MAX_DIM);
		else n = DW'(size_q);
	end
	logic [6:0] total;
	assign total = 7'(n * n);

	// sequencer counters
	logic [IW-1:0] j_q, i_q, tpos_q, row_q;
	logic [CW-1:0] k_q;
	logic [1:0]    ph_q;
	logic [SB-1:0] best_q, fac_q, tmp_q, base_q, res_q;
	logic [ICW-1:0] inv_cnt_q;
	logic          rd_vld_s1;
	logic [IW-1:0] rd_row_s1;

	logic [SB-1:0] mul_a, mul_b, mul_p_s1;
	logic [SB-1:0] poly_lo;
	assign poly_lo = SB'(poly_q);
	gji_gf_mul #(.SB(SB)) u_mul (.clk(clk), .a(mul_a), .b(mul_b), .poly(poly_lo),
		.p_s1(mul_p_s1));

	function automatic logic [AW-1:0] adr(input logic [IW-1:0] r, input logic [CW-1:0] c);
		return {r, c};
	endfunction

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_s1 <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_W'(8);
			poly_q <= POLY_W'(285);
		end else if (cfg_we) begin
			if (cfg_index == REG_MATRIX_SIZE) size_q <= cfg_data[SIZE_W-1:0];
			else poly_q <= cfg_data[POLY_W-1:0];
		end
	end

	logic [6:0] pos;
	assign pos = load_q;
	logic [IW-1:0] lrow;
	logic [CW-1:0] lcol;
	always_comb begin
		lrow = '0;
		lcol = '0;
		for (int r = 0; r < MAX_DIM; r++)
			for (int c = 0; c < MAX_DIM; c++)
				if (32'(pos) == r * 32'(n) + c && c < 32'(n)) begin
					lrow = IW'(r);
					lcol = CW'(c);
				end
	end

	logic [CW-1:0] n2;
	assign n2 = CW'({n, 1'b0});
	logic [CW-1:0] nc;
	assign nc = CW'(n);
	logic in_fire, out_fire;
	assign in_ch.ready = (state_q == ST_LOAD);
	assign in_fire = in_ch.valid && in_ch.ready;
	assign out_fire = out_ch.valid && out_ch.ready;

	// pivot search: first row holding the largest value wins
	logic          piv_take;
	logic [SB-1:0] piv_val;
	logic [IW-1:0] piv_row;
	assign piv_take = (rd_row_s1 == j_q) || (rd_s1 > best_q);
	assign piv_val = piv_take ? rd_s1 : best_q;
	assign piv_row = piv_take ? rd_row_s1 : tpos_q;

	// out stage: one-entry output register fed by a RAM read
	logic          oval_q;
	logic [SB-1:0] odat_q;
	logic          olast_q, osing_q;
	logic [IW-1:0] orow_q, ocol_q;
	logic          ordy_s1, olast_s1;
	logic          issue;
	assign issue = (state_q == ST_OUT) && !ordy_s1 && (!oval_q || out_fire);
	assign out_ch.valid = oval_q;
	assign out_ch.data = {odat_q, olast_q, osing_q};

	always_comb begin
		raddr = '0;
		we = 1'b0;
		waddr = '0;
		wdata = '0;
		mul_a = rd_s1;
		mul_b = fac_q;
		unique case (state_q)
			ST_LOAD: begin
				we = in_fire && (pos < total);
				waddr = adr(lrow, lcol);
				wdata = SB'(in_ch.data);
			end
			ST_INIT: begin
				we = 1'b1;
				waddr = adr(row_q, k_q);
				wdata = (k_q == nc + CW'(row_q)) ? SB'(1) : '0;
			end
			ST_PIV_RD: raddr = adr(i_q, CW'(j_q));
			ST_PIV_CMP: raddr = adr(i_q, CW'(j_q));
			ST_SWAP: begin
				raddr = (ph_q == 2'd0) ? adr(j_q, k_q) : adr(tpos_q, k_q);
				we = (ph_q == 2'd2) || (ph_q == 2'd3);
				waddr = (ph_q == 2'd2) ? adr(j_q, k_q) : adr(tpos_q, k_q);
				wdata = (ph_q == 2'd2) ? rd_s1 : tmp_q;
			end
			ST_INV: begin
				raddr = adr(j_q, CW'(j_q));
				// ph 2 squares the base, ph 3 folds the fresh square into res
				mul_a = (ph_q == 2'd3) ? res_q : base_q;
				mul_b = (ph_q == 2'd3) ? mul_p_s1 : base_q;
			end
			ST_NORM: begin
				raddr = adr(j_q, k_q);
				mul_b = res_q;
				we = (ph_q == 2'd2);
				waddr = adr(j_q, k_q);
				wdata = mul_p_s1;
			end
			ST_ELIM_R: raddr = adr(i_q, CW'(j_q));
			ST_ELIM: begin
				raddr = (ph_q == 2'd0) ? adr(j_q, k_q) : adr(i_q, k_q);
				we = (ph_q == 2'd3);
				waddr = adr(i_q, k_q);
				wdata = tmp_q ^ rd_s1;
			end
			ST_OUT: raddr = adr(orow_q, nc + CW'(ocol_q));
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SWAP && ph_q == 2'd1) tmp_q <= rd_s1;
		if (state_q == ST_ELIM && ph_q == 2'd2) tmp_q <= mul_p_s1;
		if (state_q == ST_ELIM_R && ph_q == 2'd1) fac_q <= rd_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			load_q <= '0;
			sing_q <= 1'b0;
			j_q <= '0; i_q <= '0; tpos_q <= '0; row_q <= '0; k_q <= '0; ph_q <= '0;
			best_q <= '0; base_q <= '0; res_q <= '0; inv_cnt_q <= '0;
			rd_vld_s1 <= 1'b0; rd_row_s1 <= '0;
			oval_q <= 1'b0; odat_q <= '0; olast_q <= 1'b0; osing_q <= 1'b0;
			orow_q <= '0; ocol_q <= '0; ordy_s1 <= 1'b0; olast_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= 1'b0;
			if (out_fire) oval_q <= 1'b0;
			if (ordy_s1) begin
				oval_q <= 1'b1;
				odat_q <= sing_q ? '0 : rd_s1;
				olast_q <= olast_s1;
				osing_q <= sing_q;
				ordy_s1 <= 1'b0;
				if (olast_s1) state_q <= ST_LOAD;
			end
			unique case (state_q)
				ST_LOAD: if (in_fire) begin
					if (7'(pos + 7'd1) < total) load_q <= pos + 7'd1;
					else begin
						load_q <= '0;
						state_q <= ST_INIT;
						row_q <= '0; k_q <= nc; j_q <= '0; sing_q <= 1'b0;
					end
				end
				ST_INIT: begin
					if (k_q == n2 - CW'(1)) begin
						k_q <= nc;
						if (DW'(row_q) == n - DW'(1)) begin
							state_q <= ST_PIV_RD;
							i_q <= j_q; tpos_q <= j_q; best_q <= '0; ph_q <= '0;
						end else row_q <= row_q + IW'(1);
					end else k_q <= k_q + CW'(1);
				end
				ST_PIV_RD: begin
					// issue read for row i_q, compare on the next cycle
					rd_row_s1 <= i_q;
					rd_vld_s1 <= 1'b1;
					state_q <= ST_PIV_CMP;
				end
				ST_PIV_CMP: begin
					if (rd_vld_s1) begin
						best_q <= piv_val;
						tpos_q <= piv_row;
						if (DW'(rd_row_s1) == n - DW'(1)) begin
							if (piv_val == '0) begin
								sing_q <= 1'b1;
								state_q <= ST_OUT;
								orow_q <= '0; ocol_q <= '0;
							end else begin
								k_q <= '0; ph_q <= '0;
								state_q <= (piv_row != j_q) ? ST_SWAP : ST_INV;
							end
						end else begin
							i_q <= rd_row_s1 + IW'(1);
							state_q <= ST_PIV_RD;
						end
					end
				end
				ST_SWAP: begin
					// ph 0 read j, 1 read tpos/latch j, 2 write j, 3 write tpos
					ph_q <= ph_q + 2'd1;
					if (ph_q == 2'd3) begin
						if (k_q == n2 - CW'(1)) begin
							k_q <= '0;
							state_q <= ST_INV;
						end else k_q <= k_q + CW'(1);
					end
				end
				ST_INV: begin
					// b^(2^SB-2) as the product of b^2, b^4, ... b^(2^(SB-1))
					if (ph_q == 2'd0) begin
						ph_q <= 2'd1;
					end else if (ph_q == 2'd1) begin
						base_q <= rd_s1; res_q <= SB'(1); inv_cnt_q <= '0;
						ph_q <= 2'd2;
					end else if (ph_q == 2'd2) begin
						if (inv_cnt_q != '0) res_q <= mul_p_s1;
						if (inv_cnt_q == ICW'(SB - 1)) begin
							ph_q <= '0; k_q <= '0;
							state_q <= ST_NORM;
						end else ph_q <= 2'd3;
					end else begin
						base_q <= mul_p_s1;
						inv_cnt_q <= inv_cnt_q + ICW'(1);
						ph_q <= 2'd2;
					end
				end
				ST_NORM: begin
					if (ph_q == 2'd2) begin
						ph_q <= 2'd0;
						if (k_q == n2 - CW'(1)) begin
							k_q <= '0; i_q <= '0;
							state_q <= ST_ELIM_R;
						end else k_q <= k_q + CW'(1);
					end else ph_q <= ph_q + 2'd1;
				end
				ST_ELIM_R: begin
					if (i_q == j_q) begin
						if (DW'(i_q) == n - DW'(1)) begin
							if (DW'(j_q) == n - DW'(1)) begin
								state_q <= ST_OUT; orow_q <= '0; ocol_q <= '0;
							end else begin
								j_q <= j_q + IW'(1);
								i_q <= j_q + IW'(1); tpos_q <= j_q + IW'(1);
								best_q <= '0; state_q <= ST_PIV_RD;
							end
						end else i_q <= i_q + IW'(1);
					end else if (ph_q == 2'd1) begin
						ph_q <= '0; k_q <= '0;
						state_q <= ST_ELIM;
					end else ph_q <= 2'd1;
				end
				ST_ELIM: begin
					// ph 0 read pivot row, 1 mul + read row i, 2 latch prod, 3 write
					if (ph_q == 2'd3) begin
						ph_q <= '0;
						if (k_q == n2 - CW'(1)) begin
							if (DW'(i_q) == n - DW'(1)) begin
								if (DW'(j_q) == n - DW'(1)) begin
									state_q <= ST_OUT; orow_q <= '0; ocol_q <= '0;
								end else begin
									j_q <= j_q + IW'(1);
									i_q <= j_q + IW'(1); tpos_q <= j_q + IW'(1);
									best_q <= '0; state_q <= ST_PIV_RD;
								end
							end else begin
								i_q <= i_q + IW'(1);
								state_q <= ST_ELIM_R;
							end
						end else k_q <= k_q + CW'(1);
					end else ph_q <= ph_q + 2'd1;
				end
				ST_OUT: if (issue) begin
					ordy_s1 <= 1'b1;
					olast_s1 <= (DW'(orow_q) == n - DW'(1)) && (DW'(ocol_q) == n - DW'(1));
					if (DW'(ocol_q) == n - DW'(1)) begin
						ocol_q <= '0; orow_q <= orow_q + IW'(1);
					end else ocol_q <= ocol_q + IW'(1);
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	`GJI_ASSERT(a_no_in_busy, clk, arst_n, (state_q != ST_LOAD) |-> !in_ch.ready,
		"input ready outside load")
	`GJI_ASSERT(a_out_hold, clk, arst_n, (out_ch.valid && !out_ch.ready) |=> out_ch.valid,
		"output dropped while stalled")
	`GJI_ASSERT(a_sing_zero, clk, arst_n, (out_ch.valid && osing_q) |-> (odat_q == '0),
		"singular result not zero")
endmodule
